[hw/rtl/swm_pkg.sv]
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W     = $clog2(WINDOW_MAX + 1);

  localparam int SAMPLE_W    = 32;
  localparam int MEDIAN_W    = 33;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam int WS_W       = 7;

  localparam logic [WS_W-1:0]      WS_RESET        = 7'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic                       valid;
    logic [AGE_W-1:0]           age;
    logic signed [SAMPLE_W-1:0] value;
  } swm_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DELETE,
    OP_INSERT,
    OP_ROTATE
  } swm_op_t;

  typedef struct packed {
    swm_op_t                    op;
    logic signed [SAMPLE_W-1:0] x;
  } swm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELETE,
    ST_INSERT,
    ST_SCAN,
    ST_OUT
  } swm_state_t;

endpackage

[hw/rtl/swm_cell.sv]
module swm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::swm_cmd_t   cmd,
  input  swm_pkg::swm_entry_t lower,
  input  logic                lower_gt,
  input  swm_pkg::swm_entry_t upper,
  output swm_pkg::swm_entry_t entry,
  output logic                gt
);
  import swm_pkg::*;

  swm_entry_t entry_r;
  swm_entry_t entry_nxt;
  logic       rm;

  // Entries are ordered by value, and among equal values by rising age.
  assign gt = !entry_r.valid || (entry_r.value >= cmd.x);
  assign rm = entry_r.valid &&
              ((entry_r.value > cmd.x) ||
               ((entry_r.value == cmd.x) && (entry_r.age == AGE_W'(WINDOW_MAX - 1))));

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      OP_DELETE: begin
        if (rm) begin
          entry_nxt = upper;
        end
      end
      OP_INSERT: begin
        if (lower_gt) begin
          entry_nxt     = lower;
          entry_nxt.age = lower.age + AGE_W'(1);
        end else if (gt) begin
          entry_nxt.valid = 1'b1;
          entry_nxt.age   = '0;
          entry_nxt.value = cmd.x;
        end else begin
          entry_nxt.age = entry_r.age + AGE_W'(1);
        end
      end
      OP_ROTATE: begin
        entry_nxt = upper;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r.age   <= entry_nxt.age;
    entry_r.value <= entry_nxt.value;
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  assign entry = entry_r;

endmodule

[hw/rtl/swm_chain.sv]
module swm_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::swm_cmd_t   cmd,
  output swm_pkg::swm_entry_t head
);
  import swm_pkg::*;

  swm_entry_t entries [WINDOW_MAX];
  logic       gts     [WINDOW_MAX];
  swm_entry_t top_upper;

  // The top cell wraps round to the head only while the chain rotates.
  assign top_upper = (cmd.op == OP_ROTATE) ? entries[0] : '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_entry_t lower_e;
    logic       lower_g;
    swm_entry_t upper_e;

    if (i == 0) begin : g_first
      assign lower_e = '0;
      assign lower_g = 1'b0;
    end else begin : g_mid_lo
      assign lower_e = entries[i-1];
      assign lower_g = gts[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign upper_e = top_upper;
    end else begin : g_mid_hi
      assign upper_e = entries[i+1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .lower    (lower_e),
      .lower_gt (lower_g),
      .upper    (upper_e),
      .entry    (entries[i]),
      .gt       (gts[i])
    );
  end

  assign head = entries[0];

endmodule

[hw/rtl/swm_ring.sv]
module swm_ring (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [swm_pkg::AGE_W-1:0]            addr,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  wdata,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  rdata
);
  import swm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] rdata_r;

  // The slot is read before it is overwritten, giving the sample that leaves.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/sliding_window_median.sv]
// Sliding-window median filter.
// Samples arrive on the in_ stream (tdata holds one signed 32-bit sample) and
// results leave on the out_ stream (tdata holds twice the median, signed 33
// bits, zero padded to 40). The median is taken over the last window_size
// samples (0 counts as 1, over 64 as 64), written through the cfg_ APB port
// at address 0 while idle; the user must keep to this, as the block itself
// does not enforce it. No result is given until window_size samples have
// arrived since reset. The window is held in a chain of 64 sorted cells
// tagged with their age; each sample first removes the oldest entry once the
// chain is full (ST_DELETE) and is then inserted (ST_INSERT). The median is
// then found by rotating the chain once past its head (ST_SCAN) and is
// registered for output in ST_OUT; only then is the input ready for the
// next sample. After a sample that gives no result, the input is ready
// again once the insert is done. The input is taken again while a result
// still waits in the output register; if the receiver stalls past the next
// scan, the block holds the new result until the output register is free.
// Synchronous reset empties the window and sets window_size to 3.
module sliding_window_median (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [swm_pkg::IN_TDATA_W-1:0]         in_tdata,    // [31:0] sample
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [swm_pkg::OUT_TDATA_W-1:0]        out_tdata,   // [32:0] median_x2
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [swm_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [swm_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [swm_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);
  import swm_pkg::*;

  swm_state_t state_r, state_nxt;

  logic [WS_W-1:0]            window_size_r;
  logic [FILL_W-1:0]          fill_r;
  logic [AGE_W-1:0]           slot_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       full_r;
  logic [FILL_W-1:0]          k_r;
  logic                       emit_r;
  logic [AGE_W-1:0]           scan_r;
  logic [FILL_W-1:0]          rank_r;
  logic signed [SAMPLE_W-1:0] lo_r;
  logic signed [SAMPLE_W-1:0] hi_r;
  logic                       out_valid_r;
  logic signed [MEDIAN_W-1:0] out_data_r;

  logic                       in_fire;
  logic                       cfg_wr;
  logic [CFG_IDX_W-1:0]       cfg_idx;
  logic [FILL_W-1:0]          k_nxt;
  logic [FILL_W-1:0]          fill_nxt;
  logic [FILL_W-1:0]          rank_hi;
  logic [FILL_W-1:0]          rank_lo;
  logic                       in_win;
  logic                       scan_last;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] ring_rdata;
  logic signed [MEDIAN_W-1:0] median_sum;
  swm_cmd_t                   cmd;
  swm_entry_t                 head;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_WINDOW_SIZE) ?
                      {{(CFG_DATA_W-WS_W){1'b0}}, window_size_r} : '0;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    if (window_size_r == '0) begin
      k_nxt = FILL_W'(1);
    end else if (32'(window_size_r) > 32'(WINDOW_MAX)) begin
      k_nxt = FILL_W'(WINDOW_MAX);
    end else begin
      k_nxt = FILL_W'(window_size_r);
    end
  end

  assign fill_nxt  = (32'(fill_r) < 32'(WINDOW_MAX)) ? fill_r + FILL_W'(1) : fill_r;
  assign rank_hi   = k_r >> 1;
  assign rank_lo   = k_r[0] ? rank_hi : rank_hi - FILL_W'(1);
  assign in_win    = head.valid && ({{(FILL_W-AGE_W){1'b0}}, head.age} < k_r);
  assign scan_last = (scan_r == AGE_W'(WINDOW_MAX - 1));
  assign median_sum = MEDIAN_W'(lo_r) + MEDIAN_W'(hi_r);

  swm_ring u_ring (
    .clk   (clk),
    .wr_en (in_fire),
    .addr  (slot_r),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .rdata (ring_rdata)
  );

  swm_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .head  (head)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DELETE;
        end
      end
      ST_DELETE: state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = emit_r ? ST_SCAN : ST_IDLE;
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_HOLD;
    cmd.x     = sample_r;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DELETE: begin
        cmd.op = full_r ? OP_DELETE : OP_HOLD;
        cmd.x  = ring_rdata;
      end
      ST_INSERT: cmd.op = OP_INSERT;
      ST_SCAN:   cmd.op = OP_ROTATE;
      default: begin
        in_tready = 1'b0;
        cmd.op    = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_size_r <= WS_RESET;
      fill_r        <= '0;
      slot_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (cfg_idx == REG_WINDOW_SIZE)) begin
        window_size_r <= cfg_pwdata[WS_W-1:0];
      end
      if (in_fire) begin
        fill_r <= fill_nxt;
        slot_r <= (slot_r == AGE_W'(WINDOW_MAX - 1)) ? '0 : slot_r + AGE_W'(1);
      end
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
      full_r   <= (32'(fill_r) == 32'(WINDOW_MAX));
      k_r      <= k_nxt;
      emit_r   <= (fill_nxt >= k_nxt);
    end
    if (state_r == ST_INSERT) begin
      scan_r <= '0;
      rank_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_r <= scan_r + AGE_W'(1);
      if (in_win) begin
        rank_r <= rank_r + FILL_W'(1);
        if (rank_r == rank_lo) begin
          lo_r <= head.value;
        end
        if (rank_r == rank_hi) begin
          hi_r <= head.value;
        end
      end
    end
    if ((state_r == ST_OUT) && out_free) begin
      out_data_r <= median_sum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-MEDIAN_W){1'b0}}, out_data_r};

endmodule

[hw/rtl/swm_checker.sv]
module swm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [swm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [swm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input logic [swm_pkg::CFG_DATA_W-1:0]    cfg_prdata
);
  import swm_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // The block works on one sample at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken while busy");

  // A result cannot appear straight after a sample transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid) ##1 !$rose(out_tvalid))
    else $error("result appeared too early");

  // Reset restores the window size register.
  a_reset_ws: assert property (@(posedge clk)
    !rst_n |=> (cfg_paddr[CFG_ADDR_W-1:2] != REG_WINDOW_SIZE) ||
               (cfg_prdata == CFG_DATA_W'(WS_RESET)))
    else $error("window size not restored by reset");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_paddr  (cfg_paddr),
  .cfg_prdata (cfg_prdata)
);

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 50;

  localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED  = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WS       = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};

  localparam logic [WS_W-1:0] PHASE_SIZES [6] = '{7'd5, 7'd64, 7'd1, 7'd100, 7'd0, 7'd2};

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_ADDR_W-1:0]      addr;
    logic [31:0]                data;
    logic                       typed;
    logic signed [MEDIAN_W-1:0] median_x2;
  } stim_row_t;

  // Rows with a typed median_x2 are checked against that value directly.
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{ROW_SAMPLE, ADDR_WS,       32'h8000_0000, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h7FFF_FFFF, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h0000_0000, 1'b1, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h7FFF_FFFF, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, ADDR_WS,       32'h7FFF_FFFF, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, ADDR_WS,       32'h8000_0000, 1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, ADDR_WS,       32'h8000_0000, 1'b1, 33'h1_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h8000_0000, 1'b1, 33'h1_0000_0000},
    '{ROW_WRITE,  ADDR_WS,       32'hFFFF_FF80, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h1234_5678, 1'b1, 33'h0_2468_ACF0},
    '{ROW_SAMPLE, ADDR_WS,       32'h8000_0000, 1'b1, 33'h1_0000_0000},
    '{ROW_WRITE,  ADDR_WS,       32'h0000_0002, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h7FFF_FFFF, 1'b1, 33'h1_FFFF_FFFF},
    '{ROW_SAMPLE, ADDR_WS,       32'hFFFF_FFFF, 1'b1, 33'h0_7FFF_FFFE},
    '{ROW_WRITE,  ADDR_WS,       32'h0000_0004, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h0000_0007, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h0000_0007, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'hFFFF_FFFD, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h0000_0007, 1'b1, 33'h0_0000_000E},
    '{ROW_WRITE,  ADDR_UNMAPPED, 32'h0000_0001, 1'b0, 33'h0_0000_0000},
    '{ROW_SAMPLE, ADDR_WS,       32'h0000_0007, 1'b1, 33'h0_0000_000E},
    '{ROW_WRITE,  ADDR_WS,       32'h0000_007F, 1'b0, 33'h0_0000_0000}
  };

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;    // [31:0] sample
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;           // [32:0] median_x2
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  sliding_window_median dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  bit          src_steady     = 1'b0;
  bit          sink_steady    = 1'b0;

  logic [WS_W-1:0]  window_size_reg = WS_RESET;
  logic [31:0]      history [WINDOW_MAX];
  logic [AGE_W-1:0] write_slot      = '0;
  int unsigned      samples_seen    = 0;

  logic signed [MEDIAN_W-1:0] pending_medians [$];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic longint value_at_rank(input longint vals [WINDOW_MAX],
                                           input int unsigned count, input int unsigned rank);
    int unsigned below;
    int unsigned same;
    for (int unsigned i = 0; i < count; i++) begin
      below = 0;
      same  = 0;
      for (int unsigned j = 0; j < count; j++) begin
        if (vals[j] < vals[i]) below++;
        else if (vals[j] == vals[i]) same++;
      end
      if (below <= rank && rank < below + same) return vals[i];
    end
    return 0;
  endfunction

  // Takes one sample into the window; returns whether a median is due.
  function automatic bit take_sample(input logic [31:0] sample,
                                     output logic signed [MEDIAN_W-1:0] median_x2);
    int unsigned span;
    longint      window_vals [WINDOW_MAX];
    logic [AGE_W-1:0] slot;
    span = (window_size_reg == 0) ? 1 :
           (window_size_reg > WINDOW_MAX) ? WINDOW_MAX : int'(window_size_reg);
    history[write_slot] = sample;
    write_slot = write_slot + AGE_W'(1);
    if (samples_seen < WINDOW_MAX) samples_seen++;
    median_x2 = '0;
    if (samples_seen < span) return 1'b0;
    for (int unsigned i = 0; i < span; i++) begin
      slot = write_slot - AGE_W'(i + 1);
      window_vals[i] = longint'($signed(history[slot]));
    end
    median_x2 = MEDIAN_W'(value_at_rank(window_vals, span, (span - 1) / 2) +
                          value_at_rank(window_vals, span, span / 2));
    return 1'b1;
  endfunction

  task automatic send_sample(input logic [31:0] sample, input logic typed,
                             input logic signed [MEDIAN_W-1:0] typed_median);
    int gap;
    bit due;
    logic signed [MEDIAN_W-1:0] median_x2;
    if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    due = take_sample(sample, median_x2);
    if (typed) pending_medians = {pending_medians, typed_median};
    else if (due) pending_medians = {pending_medians, median_x2};
  endtask

  // The window size is only changed once the filter has drained.
  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr[CFG_ADDR_W-1:2] == REG_WINDOW_SIZE) window_size_reg = value[WS_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_WS;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[WS_W-1:0] !== window_size_reg)
      report_mismatch($sformatf("window_size reads %0d, expected %0d",
                                cfg_prdata[WS_W-1:0], window_size_reg));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 16)) - 32'd8;
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h8000_0001;
          default: return 32'h7FFF_FFFE;
        endcase
      end
      default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FF00) |
                      32'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    logic [WS_W-1:0] size;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
        write_register(DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].data);
      end else begin
        send_sample(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].median_x2);
      end
    end
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) size = PHASE_SIZES[phase];
      else if ($urandom_range(0, 3) == 0) size = WS_W'($urandom_range(17, 127));
      else size = WS_W'($urandom_range(1, 16));
      write_register(ADDR_WS, ($urandom() & 32'hFFFF_FF80) | 32'(size));
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(draw_sample(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : median_check
    logic signed [MEDIAN_W-1:0] got;
    logic signed [MEDIAN_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      got = $signed(out_tdata[MEDIAN_W-1:0]);
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("median_x2 %0d with no transfer pending", got));
      end else begin
        want = pending_medians.pop_front();
        if (got !== want) report_mismatch($sformatf("median_x2 %0d, expected %0d", got, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
